// ===== rtl/core/gqd_pkg.sv =====
`default_nettype none
package gqd_pkg;

  localparam int GQD_SAMPLE_WIDTH = 16;
  localparam int AXIS_IDX_W       = 3;
  localparam int ORDER_W          = 2;
  localparam int SYM_BITS_W       = 6;
  localparam int BIT_CNT_W        = 3;
  localparam int OUT_TDATA_W      = ((SYM_BITS_W + BIT_CNT_W + 7) / 8) * 8;

  localparam logic [ORDER_W-1:0] MOD_QPSK  = 2'd0;
  localparam logic [ORDER_W-1:0] MOD_QAM16 = 2'd1;
  localparam logic [ORDER_W-1:0] MOD_QAM64 = 2'd2;

  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
    logic ld_out;
  } gqd_stage_en_t;

  // axis index of the positive level with magnitude 2c+1
  function automatic logic [AXIS_IDX_W-1:0] gqd_pos_index(
    input logic [ORDER_W-1:0] ord,
    input logic [1:0]         c
  );
    logic [AXIS_IDX_W-1:0] idx;
    idx = '0;
    unique case (ord)
      MOD_QPSK: begin
        idx = 3'd0;
      end
      MOD_QAM16: begin
        idx = (c == 2'd0) ? 3'd0 : 3'd2;
      end
      default: begin
        unique case (c)
          2'd0: idx = 3'd4;
          2'd1: idx = 3'd0;
          2'd2: idx = 3'd2;
          default: idx = 3'd6;
        endcase
      end
    endcase
    return idx;
  endfunction

  function automatic logic [BIT_CNT_W-1:0] gqd_bit_count(input logic [ORDER_W-1:0] ord);
    logic [BIT_CNT_W-1:0] n;
    n = '0;
    unique case (ord)
      MOD_QPSK:  n = 3'd2;
      MOD_QAM16: n = 3'd4;
      default:   n = 3'd6;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gray_qam_hard_demapper_core.sv =====
`default_nettype none
// gray-coded qam hard demapper (qpsk, 16qam, 64qam)
// input stream: one request per i/q sample, in_tdata carries sample_i in the
//   low SAMPLE_WIDTH bits and sample_q above it (signed, SAMPLE_WIDTH-4 frac bits)
// output stream: one request per sample, out_tdata = symbol_bits [5:0],
//   bit_count [8:6], zeros above; bit 2k is i index bit k, bit 2k+1 q index bit k
// config: cfg_wr_en writes cfg_wr_data as the modulation order
//   (0 qpsk, 1 16qam, 2 64qam, 3 acts as 64qam); write only while idle
// pipeline: four register stages; an accepted sample passes stage one, stage two,
//   stage three and the output register before out_tvalid rises
// throughput: one sample per clock unless stalled; each axis lane registers
//   magnitude, square and power scaling, then the threshold compare feeds the
//   merge stage, which interleaves both axis indexes into the output register
// reset: pipeline emptied, order returns to qpsk
// a stalled receiver holds the output; the stages ahead keep filling any
//   bubbles, and in_tready drops only once every stage holds a sample
module gray_qam_hard_demapper_core
  import gqd_pkg::*;
#(
  parameter  int SAMPLE_WIDTH = GQD_SAMPLE_WIDTH,
  localparam int IN_TDATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // sample_i, sample_q
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // symbol_bits, bit_count
  input  wire logic                   cfg_wr_en,
  input  wire logic [ORDER_W-1:0]     cfg_wr_data
);

  logic [ORDER_W-1:0]    mod_order_r;
  logic [ORDER_W-1:0]    ord_in;
  logic [ORDER_W-1:0]    ord1_r, ord2_r, ord3_r;
  logic                  v1_r, v2_r, v3_r, vo_r;
  logic                  rdy1, rdy2, rdy3, rdyo;
  gqd_stage_en_t         en;
  logic [AXIS_IDX_W-1:0] idx_i, idx_q;
  logic [SYM_BITS_W-1:0] symbol_bits;
  logic [BIT_CNT_W-1:0]  bit_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_order_r <= MOD_QPSK;
    end else if (cfg_wr_en) begin
      mod_order_r <= cfg_wr_data;
    end
  end

  assign ord_in = (mod_order_r > MOD_QAM64) ? MOD_QAM64 : mod_order_r;

  // a stage takes new data when it is empty or its content moves on
  assign rdyo = !vo_r || out_tready;
  assign rdy3 = !v3_r || rdyo;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign en.ld_s1  = rdy1 && in_tvalid;
  assign en.ld_s2  = rdy2 && v1_r;
  assign en.ld_s3  = rdy3 && v2_r;
  assign en.ld_out = rdyo && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_s1) ord1_r <= ord_in;
    if (en.ld_s2) ord2_r <= ord1_r;
    if (en.ld_s3) ord3_r <= ord2_r;
  end

  gqd_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_i (
    .clk    (clk),
    .en     (en),
    .sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .ord_s2 (ord2_r),
    .ord_s3 (ord3_r),
    .idx    (idx_i)
  );

  gqd_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_q (
    .clk    (clk),
    .en     (en),
    .sample (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .ord_s2 (ord2_r),
    .ord_s3 (ord3_r),
    .idx    (idx_q)
  );

  gqd_merge u_merge (
    .clk         (clk),
    .ld          (en.ld_out),
    .ord         (ord3_r),
    .idx_i       (idx_i),
    .idx_q       (idx_q),
    .symbol_bits (symbol_bits),
    .bit_count   (bit_count)
  );

  assign out_tvalid = vo_r;
  assign out_tdata  = {(OUT_TDATA_W - SYM_BITS_W - BIT_CNT_W)'(0), bit_count, symbol_bits};

`ifndef SYNTHESIS
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy3 |=> v3_r)
    else $error("stage three dropped a sample while blocked");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted sample did not enter stage one");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (bit_count == 3'd2 || bit_count == 3'd4 || bit_count == 3'd6))
    else $error("bad bit count on output");

  a_qpsk_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && bit_count == 3'd2 |-> symbol_bits[SYM_BITS_W-1:2] == '0)
    else $error("qpsk result has upper bits set");

  a_qam16_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && bit_count == 3'd4 |-> symbol_bits[SYM_BITS_W-1:4] == '0)
    else $error("16qam result has upper bits set");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/gqd_lane.sv =====
`default_nettype none
module gqd_lane
  import gqd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = GQD_SAMPLE_WIDTH
) (
  input  wire logic                    clk,
  input  wire gqd_stage_en_t           en,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  input  wire logic [ORDER_W-1:0]      ord_s2,
  input  wire logic [ORDER_W-1:0]      ord_s3,
  output logic      [AXIS_IDX_W-1:0]   idx
);

  localparam int SQ_W    = 2 * SAMPLE_WIDTH;
  localparam int PW_W    = SQ_W + 6;
  localparam int THR_SH  = 2 * (SAMPLE_WIDTH - 4) + 2;

  localparam logic [PW_W-1:0] THR1 = PW_W'(1) << THR_SH;
  localparam logic [PW_W-1:0] THR2 = PW_W'(4) << THR_SH;
  localparam logic [PW_W-1:0] THR3 = PW_W'(9) << THR_SH;

  logic                    neg_nxt;
  logic [SAMPLE_WIDTH-1:0] mag_nxt;
  logic [SAMPLE_WIDTH-1:0] mag_r;
  logic                    neg1_r;
  logic [SQ_W-1:0]         sq_nxt;
  logic [SQ_W-1:0]         sq_r;
  logic                    neg2_r;
  logic [PW_W-1:0]         pw_nxt;
  logic [PW_W-1:0]         pw_r;
  logic                    neg3_r;
  logic                    gt1, gt2, gt3;
  logic [1:0]              lvl;
  logic [AXIS_IDX_W-1:0]   pos_idx;

  // the most negative code maps to 2^(w-1), still fits unsigned
  assign neg_nxt = sample[SAMPLE_WIDTH-1];
  assign mag_nxt = neg_nxt ? (~sample + 1'b1) : sample;

  always_ff @(posedge clk) begin
    if (en.ld_s1) begin
      mag_r  <= mag_nxt;
      neg1_r <= neg_nxt;
    end
  end

  assign sq_nxt = SQ_W'(mag_r) * SQ_W'(mag_r);

  always_ff @(posedge clk) begin
    if (en.ld_s2) begin
      sq_r   <= sq_nxt;
      neg2_r <= neg1_r;
    end
  end

  // scale by mean symbol power 2, 10 or 42
  always_comb begin
    unique case (ord_s2)
      MOD_QPSK:  pw_nxt = PW_W'(sq_r) << 1;
      MOD_QAM16: pw_nxt = (PW_W'(sq_r) << 3) + (PW_W'(sq_r) << 1);
      default:   pw_nxt = (PW_W'(sq_r) << 5) + (PW_W'(sq_r) << 3) + (PW_W'(sq_r) << 1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.ld_s3) begin
      pw_r   <= pw_nxt;
      neg3_r <= neg2_r;
    end
  end

  assign gt1 = pw_r > THR1;
  assign gt2 = pw_r > THR2;
  assign gt3 = pw_r > THR3;

  // thresholds are increasing, so the count is a priority pick
  always_comb begin
    unique case (ord_s3)
      MOD_QPSK:  lvl = 2'd0;
      MOD_QAM16: lvl = gt1 ? 2'd1 : 2'd0;
      default: begin
        priority if (gt3) lvl = 2'd3;
        else if (gt2)     lvl = 2'd2;
        else if (gt1)     lvl = 2'd1;
        else              lvl = 2'd0;
      end
    endcase
  end

  assign pos_idx = gqd_pos_index(ord_s3, lvl);
  // positive level indexes are even, the negative twin is the next one
  assign idx     = {pos_idx[AXIS_IDX_W-1:1], neg3_r};

endmodule
`default_nettype wire

// ===== rtl/core/gqd_merge.sv =====
`default_nettype none
module gqd_merge
  import gqd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  ld,
  input  wire logic [ORDER_W-1:0]    ord,
  input  wire logic [AXIS_IDX_W-1:0] idx_i,
  input  wire logic [AXIS_IDX_W-1:0] idx_q,
  output logic      [SYM_BITS_W-1:0] symbol_bits,
  output logic      [BIT_CNT_W-1:0]  bit_count
);

  logic [SYM_BITS_W-1:0] bits_nxt;
  logic [SYM_BITS_W-1:0] bits_r;
  logic [BIT_CNT_W-1:0]  cnt_r;

  // unused upper index bits are already zero for the smaller orders
  always_comb begin
    for (int k = 0; k < AXIS_IDX_W; k++) begin
      bits_nxt[2*k]   = idx_i[k];
      bits_nxt[2*k+1] = idx_q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      bits_r <= bits_nxt;
      cnt_r  <= gqd_bit_count(ord);
    end
  end

  assign symbol_bits = bits_r;
  assign bit_count   = cnt_r;

endmodule
`default_nettype wire

// ===== tb/gray_qam_hard_demapper_core_tb.sv =====
`timescale 1ns / 1ps
module gray_qam_hard_demapper_core_tb;
  import gqd_pkg::*;

  localparam int SW = GQD_SAMPLE_WIDTH;
  localparam int FRAC = SW - 4;
  localparam logic [ORDER_W-1:0] MOD_SATURATED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PER_SETTING = 72;

  typedef struct packed {
    logic [SYM_BITS_W-1:0] symbol_bits;
    logic [BIT_CNT_W-1:0]  bit_count;
  } decision_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*SW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [ORDER_W-1:0] cfg_wr_data = '0;

  decision_t pending_decisions[$];
  decision_t expected_now;
  logic [ORDER_W-1:0] active_order = MOD_QPSK;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int result_count = 0;
  int cycle_count = 0;

  gray_qam_hard_demapper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // sample_i, sample_q
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // symbol_bits, bit_count
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // index of the level nearest to one axis component, exact integer compare
  function automatic logic [AXIS_IDX_W-1:0] nearest_axis_index(
    input logic [SW-1:0] raw,
    input logic [ORDER_W-1:0] ord
  );
    logic [63:0] mag;
    logic [63:0] thr;
    logic [63:0] pwr;
    int half_levels;
    int c;
    logic [AXIS_IDX_W-1:0] pos;
    mag = raw[SW-1] ? ((64'd1 << SW) - 64'(raw)) : 64'(raw);
    case (ord)
      MOD_QPSK: begin
        pwr = 64'd2;
        half_levels = 1;
      end
      MOD_QAM16: begin
        pwr = 64'd10;
        half_levels = 2;
      end
      default: begin
        pwr = 64'd42;
        half_levels = 4;
      end
    endcase
    c = 0;
    for (int m = 1; m < half_levels; m++) begin
      thr = 64'(m) << (FRAC + 1);
      if (mag * mag * pwr > thr * thr) c++;
    end
    // gray order puts the positive level of magnitude 2c+1 at these indexes
    case (ord)
      MOD_QPSK:  pos = 3'd0;
      MOD_QAM16: pos = (c == 0) ? 3'd0 : 3'd2;
      default: begin
        case (c)
          0: pos = 3'd4;
          1: pos = 3'd0;
          2: pos = 3'd2;
          default: pos = 3'd6;
        endcase
      end
    endcase
    return pos + AXIS_IDX_W'(raw[SW-1]);
  endfunction

  function automatic decision_t predict_decision(
    input logic [SW-1:0] si,
    input logic [SW-1:0] sq,
    input logic [ORDER_W-1:0] ord
  );
    decision_t d;
    logic [AXIS_IDX_W-1:0] ii;
    logic [AXIS_IDX_W-1:0] qi;
    int nb;
    ii = nearest_axis_index(si, ord);
    qi = nearest_axis_index(sq, ord);
    nb = (ord == MOD_QPSK) ? 1 : (ord == MOD_QAM16) ? 2 : 3;
    d.symbol_bits = '0;
    for (int k = 0; k < nb; k++) begin
      d.symbol_bits[2*k]   = ii[k];
      d.symbol_bits[2*k+1] = qi[k];
    end
    d.bit_count = BIT_CNT_W'(2 * nb);
    return d;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             field, result_count, got, want);
    error_count++;
  endtask

  // one request on the input stream; valid stays up for a following request
  task automatic send_sample(input logic [SW-1:0] si, input logic [SW-1:0] sq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sq, si};
    do @(posedge clk); while (!in_tready);
    pending_decisions = {pending_decisions, predict_decision(si, sq, active_order)};
  endtask

  task automatic set_order(input logic [ORDER_W-1:0] ord);
    in_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ord;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_order = ord;
  endtask

  function automatic logic [SW-1:0] random_sample();
    logic [SW-1:0] v;
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) v = SW'($urandom_range(4600));
    else if (pick < 5) v = SW'($urandom_range(64));
    else return SW'($urandom);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        expected_now = pending_decisions.pop_front();
        if (out_tdata[SYM_BITS_W-1:0] !== expected_now.symbol_bits)
          report_mismatch("symbol_bits", int'(out_tdata[SYM_BITS_W-1:0]),
                          int'(expected_now.symbol_bits));
        if (out_tdata[SYM_BITS_W +: BIT_CNT_W] !== expected_now.bit_count)
          report_mismatch("bit_count", int'(out_tdata[SYM_BITS_W +: BIT_CNT_W]),
                          int'(expected_now.bit_count));
        if (out_tdata[OUT_TDATA_W-1:SYM_BITS_W+BIT_CNT_W] !== '0)
          report_mismatch("padding",
                          int'(out_tdata[OUT_TDATA_W-1:SYM_BITS_W+BIT_CNT_W]), 0);
      end
      result_count++;
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // zero samples, full-scale extremes and signs in qpsk
  task automatic test_qpsk_corners();
    set_order(MOD_QPSK);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd1, -16'sd1);
  endtask

  // just inside and just outside the inner boundary, full scale, near zero
  task automatic test_qam16_thresholds();
    set_order(MOD_QAM16);
    send_sample(16'sd2590, -16'sd2590);
    send_sample(16'sd2591, -16'sd2591);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd0, -16'sd1);
  endtask

  task automatic test_qam64_thresholds();
    set_order(MOD_QAM64);
    send_sample(16'sd1264, -16'sd1265);
    send_sample(16'sd1265, -16'sd1264);
    send_sample(16'sd2528, 16'sd2529);
    send_sample(-16'sd2529, -16'sd2528);
    send_sample(16'sd3792, -16'sd3793);
    send_sample(-16'sd3792, 16'sd3793);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(16'sd0, 16'sd0);
  endtask

  // the unused order code falls back to 64qam
  task automatic test_order_three();
    set_order(MOD_SATURATED);
    send_sample(16'sd3793, -16'sd1264);
    send_sample(16'sd0, -16'sd32768);
    send_sample(-16'sd1, 16'sd2529);
  endtask

  task automatic test_random_streams();
    int idle_mix[4][2];
    idle_mix = '{'{0, 0}, '{48, 0}, '{0, 48}, '{34, 34}};
    for (int p = 0; p < 4; p++) begin
      for (int ord = 0; ord < 4; ord++) begin
        set_order(ORDER_W'(ord));
        send_idle_pct  = idle_mix[p][0];
        recv_stall_pct = idle_mix[p][1];
        repeat (RANDOM_PER_SETTING) send_sample(random_sample(), random_sample());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_qpsk_corners();
    test_qam16_thresholds();
    test_qam64_thresholds();
    test_order_three();
    test_random_streams();
    in_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
